/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the tile pattern emboss renderer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk while out of reset.
`define TPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define TPE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/tpe_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the tile pattern emboss renderer.
package tpe_pkg;

  localparam int unsigned BYTE_IDX_W = 7;
  localparam int unsigned TILE_DIM   = 16;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned COLOR_W    = 8;
  localparam logic [BYTE_IDX_W-1:0] LAST_BYTE = 7'd127;

  // Quadrant offsets in pattern order: top-left, bottom-left, top-right, bottom-right
  localparam logic [POS_W-1:0] QUAD_ROW_BASE [4] = '{4'd0, 4'd8, 4'd0, 4'd8};
  localparam logic [POS_W-1:0] QUAD_COL_BASE [4] = '{4'd0, 4'd0, 4'd8, 4'd8};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EMBOSS_MODE = 3'd0,
    REG_FOREGROUND  = 3'd1,
    REG_HIGHLIGHT   = 3'd2,
    REG_MID         = 3'd3,
    REG_SHADOW      = 3'd4,
    REG_BACKGROUND  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] pattern_byte;
    logic [8:0] origin_x;
    logic [8:0] origin_y;
  } in_t;

  typedef struct packed {
    logic [9:0]         pixel_x;
    logic [9:0]         pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_of_pair;
    logic               tile_done;
  } out_t;

  typedef struct packed {
    logic               emboss_mode;
    logic [COLOR_W-1:0] foreground_color;
    logic [COLOR_W-1:0] highlight_color;
    logic [COLOR_W-1:0] mid_color;
    logic [COLOR_W-1:0] shadow_color;
    logic [COLOR_W-1:0] background_color;
  } cfg_t;

  // One two-pixel update of the set/clear map
  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] row;
    logic [POS_W-2:0] pair;
    logic [1:0]       bits;
  } map_wr_t;

  localparam cfg_t CFG_RESET = '{
    emboss_mode:      1'b1,
    foreground_color: 8'd1,
    highlight_color:  8'd15,
    mid_color:        8'd8,
    shadow_color:     8'd2,
    background_color: 8'd0
  };

  function automatic logic [POS_W-1:0] tile_row(input logic [BYTE_IDX_W-1:0] k);
    return POS_W'({1'b0, k[4:2]}) + QUAD_ROW_BASE[k[6:5]];
  endfunction

  function automatic logic [POS_W-1:0] tile_col(input logic [BYTE_IDX_W-1:0] k);
    return POS_W'({1'b0, k[1:0], 1'b0}) + QUAD_COL_BASE[k[6:5]];
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color(input cfg_t c, input logic here,
                                                    input logic ul);
    logic [COLOR_W-1:0] color;
    if (!c.emboss_mode) begin
      color = here ? c.foreground_color : c.background_color;
    end else if (here && !ul) begin
      color = c.highlight_color;
    end else if (!here && ul) begin
      color = c.shadow_color;
    end else if (here && ul) begin
      color = c.mid_color;
    end else begin
      color = c.background_color;
    end
    return color;
  endfunction

endpackage

/* rtl/tpe_map.sv */
`timescale 1ns / 1ps
// Set/clear bit map of the tile: 16 rows, written two pixels at a time.
module tpe_map (
  input  logic             clk,
  input  tpe_pkg::map_wr_t wr,
  input  logic [3:0]       rd_row,
  output logic [15:0]      rd_bits
);
  import tpe_pkg::*;

  logic [TILE_DIM/2-1:0][1:0] rows_r [TILE_DIM];

  // Write one pixel pair of one row
  always_ff @(posedge clk) begin
    if (wr.en) begin
      rows_r[wr.row][wr.pair] <= wr.bits;
    end
  end

  // Read the row above the current one
  assign rd_bits = rows_r[rd_row];

endmodule

/* rtl/tpe_color.sv */
`timescale 1ns / 1ps
// Per-byte pixel logic: positions, emboss colors and the map update for one pattern byte.
module tpe_color (
  input  tpe_pkg::in_t     item,
  input  logic [6:0]       k,
  input  tpe_pkg::cfg_t    cfg,
  input  logic             wr_en,
  input  logic [15:0]      above_bits,
  output logic [3:0]       above_row,
  output tpe_pkg::map_wr_t map_wr,
  output tpe_pkg::out_t    left_px,
  output tpe_pkg::out_t    right_px
);
  import tpe_pkg::*;

  logic [POS_W-1:0] row;
  logic [POS_W-1:0] col;
  logic [POS_W-1:0] col_m1;
  logic             left_set;
  logic             right_set;
  logic             ul_left;
  logic             ul_right;
  logic [9:0]       y_pos;

  // Locate the byte inside the tile
  assign row       = tile_row(k);
  assign col       = tile_col(k);
  assign col_m1    = col - POS_W'(1);
  assign above_row = row - POS_W'(1);

  assign left_set  = item.pattern_byte[7:4] != 4'h0;
  assign right_set = item.pattern_byte[3:0] != 4'h0;

  // Upper-left neighbors; anything outside the tile counts as clear
  assign ul_left  = (row != '0) && (col != '0) && above_bits[col_m1];
  assign ul_right = (row != '0) && above_bits[col];

  assign y_pos = 10'({1'b0, item.origin_y}) + 10'(row);

  always_comb begin
    left_px.pixel_x      = 10'({1'b0, item.origin_x}) + 10'(col);
    left_px.pixel_y      = y_pos;
    left_px.pixel_color  = pick_color(cfg, left_set, ul_left);
    left_px.last_of_pair = 1'b0;
    left_px.tile_done    = 1'b0;

    right_px.pixel_x      = 10'({1'b0, item.origin_x}) + 10'({col[POS_W-1:1], 1'b1});
    right_px.pixel_y      = y_pos;
    right_px.pixel_color  = pick_color(cfg, right_set, ul_right);
    right_px.last_of_pair = 1'b1;
    right_px.tile_done    = (k == LAST_BYTE);
  end

  // Store this byte's set/clear bits, right pixel in the upper bit
  assign map_wr = '{en: wr_en, row: row, pair: col[POS_W-1:1], bits: {right_set, left_set}};

endmodule

/* rtl/tile_pattern_emboss_renderer.sv */
`timescale 1ns / 1ps
// Top level of the tile pattern emboss renderer: handshakes, registers, config and checks.
//
//  Channel  | Ports                               | Word
//  ---------+-------------------------------------+-------------------------------
//  input    | in_valid, in_ready, in_data         | pattern byte and tile origin
//  result   | out_valid, out_ready, out_data      | one pixel write
//  config   | cfg_valid, cfg_ready, cfg_index/data | one 8-bit register write
//
// Each byte produces two pixel words on the single result port, which moves one pixel
// word per cycle while out_ready holds; a new byte loads as the pair's right word drains.
// A byte is held in the input register and then the pixel pair register before its left pixel word goes out.
// Reset is synchronous; the set/clear map holds no reset and is written before it is read.
// A stall on the result side holds the pixel pair; one more byte waits in the input register.
module tile_pattern_emboss_renderer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tpe_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tpe_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tpe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpe_pkg::COLOR_W-1:0]        cfg_data
);
  import tpe_pkg::*;

`include "assert_macros.svh"

  cfg_t                  cfg_r;
  logic [BYTE_IDX_W-1:0] byte_index_r;

  logic                  in_valid_r;
  in_t                   in_r;
  logic [BYTE_IDX_W-1:0] k_r;

  logic                  pair_valid_r;
  logic                  sel_r;
  out_t                  left_r;
  out_t                  right_r;

  logic                  in_fire;
  logic                  out_fire;
  logic                  move;
  logic [POS_W-1:0]      above_row;
  logic [TILE_DIM-1:0]   above_bits;
  map_wr_t               map_wr;
  out_t                  left_px;
  out_t                  right_px;

  // Handshakes: a pair drains on its right word, which frees room for the next byte
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign move      = in_valid_r && (!pair_valid_r || (out_ready && sel_r));
  assign in_ready  = !in_valid_r || move;
  assign out_valid = pair_valid_r;
  assign out_data  = sel_r ? right_r : left_r;
  assign cfg_ready = 1'b1;

  tpe_map u_map (
    .clk     (clk),
    .wr      (map_wr),
    .rd_row  (above_row),
    .rd_bits (above_bits)
  );

  tpe_color u_color (
    .item       (in_r),
    .k          (k_r),
    .cfg        (cfg_r),
    .wr_en      (move),
    .above_bits (above_bits),
    .above_row  (above_row),
    .map_wr     (map_wr),
    .left_px    (left_px),
    .right_px   (right_px)
  );

  // Control state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r        <= CFG_RESET;
      byte_index_r <= '0;
      in_valid_r   <= 1'b0;
      pair_valid_r <= 1'b0;
      sel_r        <= 1'b0;
    end else begin
      // Write a configuration register; drop unknown indexes
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_EMBOSS_MODE: cfg_r.emboss_mode      <= cfg_data[0];
          REG_FOREGROUND:  cfg_r.foreground_color <= cfg_data;
          REG_HIGHLIGHT:   cfg_r.highlight_color  <= cfg_data;
          REG_MID:         cfg_r.mid_color        <= cfg_data;
          REG_SHADOW:      cfg_r.shadow_color     <= cfg_data;
          REG_BACKGROUND:  cfg_r.background_color <= cfg_data;
          default: ;
        endcase
      end

      // Advance the byte position on every accepted word
      if (in_fire) begin
        byte_index_r <= byte_index_r + BYTE_IDX_W'(1);
        in_valid_r   <= 1'b1;
      end else if (move) begin
        in_valid_r <= 1'b0;
      end

      // Load a new pair, step from left to right word, or drain
      if (move) begin
        pair_valid_r <= 1'b1;
        sel_r        <= 1'b0;
      end else if (out_fire && sel_r) begin
        pair_valid_r <= 1'b0;
        sel_r        <= 1'b0;
      end else if (out_fire) begin
        sel_r <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
      k_r  <= byte_index_r;
    end
    if (move) begin
      left_r  <= left_px;
      right_r <= right_px;
    end
  end

  `TPE_ASSERT(a_right_follows_left, (out_fire && !out_data.last_of_pair) |=> (out_valid && out_data.last_of_pair), "left pixel word not followed by its right word")
  `TPE_ASSERT(a_done_on_right, (out_valid && out_data.tile_done) |-> out_data.last_of_pair, "tile_done seen on a left pixel word")
  `TPE_ASSERT(a_byte_moves_on, (in_valid_r && !pair_valid_r) |=> pair_valid_r, "buffered byte did not move into an empty pair stage")
  `TPE_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (!out_valid && in_ready), "control state not cleared by reset")

endmodule
